@@ rtl/dhfk_pkg.sv @@
// Shared types and constants for the DH forward-kinematics chain.
package dhfk_pkg;

  // Fraction bits of the running matrix and of the result words (Q16.16).
  localparam int FRAC_BITS = 16;

  // Full homogeneous matrix size; the bottom row is fixed and not stored.
  localparam int MAT_DIM     = 4;
  localparam int ROWS_KEPT   = MAT_DIM - 1;
  localparam int MAT_ENTRIES = ROWS_KEPT * MAT_DIM;
  localparam int MAT_AW      = $clog2(MAT_ENTRIES);

  // Column that carries the translation; its coefficients carry 15 fraction bits.
  localparam logic [1:0] COL_TR = 2'(MAT_DIM - 1);

  // 1.0 in the running-matrix format.
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  // One issue slot of the shared multiplier.
  // acc = 1: matrix product term, summed into column sel[1:0] of row 'row'.
  // acc = 0: transform term number sel, handed back raw after the multiply.
  typedef struct packed {
    logic       vld;
    logic       acc;
    logic       first;
    logic       last;
    logic [2:0] sel;
    logic [1:0] row;
  } mac_op_t;

  // Tag of a finished, rounded matrix entry.
  typedef struct packed {
    logic       vld;
    logic [1:0] col;
    logic [1:0] row;
  } mac_res_t;

endpackage

@@ rtl/dhfk_trig.sv @@
// Angle reduction and quarter-wave sine lookup for one DH row (two stages).
module dhfk_trig
  import dhfk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [9:0]  theta,
  input  logic signed [8:0]  alpha,
  output logic               vld,
  output logic signed [16:0] st,
  output logic signed [16:0] ct,
  output logic signed [16:0] sa,
  output logic signed [16:0] ca
);

  // sin(k deg), k = 0..90, unsigned Q1.15
  localparam logic [15:0] SINE_TAB [91] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  // Input spans -512..601; bias by 720, then two compare-subtract steps.
  function automatic logic [8:0] deg_mod360(input logic [10:0] x);
    logic [11:0] y;
    y = {x[10], x} + 12'd720;
    if (y >= 12'd720) y = y - 12'd720;
    if (y >= 12'd360) y = y - 12'd360;
    return y[8:0];
  endfunction

  function automatic logic signed [16:0] sine_q15(input logic [8:0] r);
    logic [8:0]         idx;
    logic               neg;
    logic signed [16:0] mag;
    if (r <= 9'd90) begin
      idx = r;
      neg = 1'b0;
    end else if (r <= 9'd180) begin
      idx = 9'd180 - r;
      neg = 1'b0;
    end else if (r <= 9'd270) begin
      idx = r - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - r;
      neg = 1'b1;
    end
    mag = signed'({1'b0, SINE_TAB[idx[6:0]]});
    return neg ? -mag : mag;
  endfunction

  logic       v1_r;
  logic [8:0] th_r, thc_r, al_r, alc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vld  <= 1'b0;
    end else begin
      v1_r <= start;
      vld  <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      th_r  <= deg_mod360(11'(theta));
      thc_r <= deg_mod360(11'(theta) + 11'd90);
      al_r  <= deg_mod360(11'(alpha));
      alc_r <= deg_mod360(11'(alpha) + 11'd90);
    end
    if (v1_r) begin
      st <= sine_q15(th_r);
      ct <= sine_q15(thc_r);
      sa <= sine_q15(al_r);
      ca <= sine_q15(alc_r);
    end
  end

endmodule

@@ rtl/dhfk_mac.sv @@
// Shared 32x32 multiplier, column accumulator and round/saturate stage.
module dhfk_mac
  import dhfk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mac_op_t            op,
  input  logic signed [31:0] mul_a,
  input  logic signed [31:0] mul_b,
  output logic signed [63:0] prod,
  output mac_op_t            ptag,
  output mac_res_t           res,
  output logic signed [31:0] res_val
);

  localparam int ROT_FRAC = 30;  // rotation coefficients
  localparam int TR_FRAC  = 15;  // translation coefficients
  localparam logic signed [63:0] HALF_ROT = 64'sd1 <<< (ROT_FRAC - 1);
  localparam logic signed [63:0] HALF_TR  = 64'sd1 <<< (TR_FRAC - 1);

  logic signed [63:0] acc_r;
  mac_res_t           atag_r;
  logic signed [63:0] rnd_y, rnd_sh;
  logic signed [31:0] rnd_sat;
  logic               is_tr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag   <= '0;
      atag_r <= '0;
      res    <= '0;
    end else begin
      ptag       <= op;
      atag_r.vld <= ptag.vld && ptag.acc && ptag.last;
      atag_r.col <= ptag.sel[1:0];
      atag_r.row <= ptag.row;
      res        <= atag_r;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ptag.vld && ptag.acc)
      acc_r <= (ptag.first ? 64'sd0 : acc_r) + prod;
    res_val <= rnd_sat;
  end

  // round half up, then clamp to 32 bits
  always_comb begin
    is_tr  = (atag_r.col == COL_TR);
    rnd_y  = acc_r + (is_tr ? HALF_TR : HALF_ROT);
    rnd_sh = is_tr ? (rnd_y >>> TR_FRAC) : (rnd_y >>> ROT_FRAC);
    if (rnd_sh > 64'sd2147483647)
      rnd_sat = 32'sh7fff_ffff;
    else if (rnd_sh < -64'sd2147483648)
      rnd_sat = 32'sh8000_0000;
    else
      rnd_sat = rnd_sh[31:0];
  end

endmodule

@@ rtl/dh_forward_kinematics_chain.sv @@
// Top level: DH forward-kinematics chain with the running matrix in block RAM.
//
// Each input word is one joint's DH row (twist, length, offset, joint angle).
// The block forms the joint's 4x4 DH transform and right-multiplies the
// running matrix by it; the product is written back and its four rows go out
// as four output words (row 3 is always 0 0 0 1.0, tlast marks it). A word
// with tuser (chain_start) set loads the joint transform as the new running
// matrix and produces no output. Entries are signed Q16.16, rounded half up
// and saturated. After reset the running matrix is the identity. A joint
// runs the sine lookup, then six transform terms and 48 matrix products
// through the single shared multiplier, and the pipeline drains after each
// of the three stored rows; a chain start skips the fixed row 3. Rows leave
// through an output register, so a new joint can be accepted while the last
// row still waits for out_tready.
module dh_forward_kinematics_chain
  import dhfk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [8:0] twist_deg, [19:9] link_length, [30:20] link_offset,
  // [40:31] joint_angle_deg, [47:41] zero
  input  logic [47:0]  in_tdata,
  // [0] chain_start
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] row_index, [33:2] col_0, [65:34] col_1, [97:66] col_2,
  // [129:98] col_3, [135:130] zero
  output logic [135:0] out_tdata,
  // last_row
  output logic         out_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRIG = 3'd1;
  localparam logic [2:0] S_TERM = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_ROW3 = 3'd5;

  // transform terms built on the multiplier
  localparam logic [2:0] TM_STCA = 3'd0;  // stored negated
  localparam logic [2:0] TM_STSA = 3'd1;
  localparam logic [2:0] TM_CTCA = 3'd2;
  localparam logic [2:0] TM_CTSA = 3'd3;  // stored negated
  localparam logic [2:0] TM_ACT  = 3'd4;
  localparam logic [2:0] TM_AST  = 3'd5;
  localparam int         N_TERMS = 6;

  localparam logic [1:0] ROW_LAST  = 2'(ROWS_KEPT - 1);
  localparam logic [1:0] ROW_FIXED = 2'(ROWS_KEPT);

  logic [2:0]         state_r, state_nxt;
  logic [3:0]         cnt_r;
  logic [1:0]         row_r;
  logic               start_r, loaded_r;
  logic signed [10:0] len_r, off_r;
  logic signed [31:0] tm_r [N_TERMS];
  logic signed [31:0] mrow_r [MAT_DIM];

  logic               in_acc, out_free, wait_go;

  // running matrix store, one read and one write port
  logic [31:0]        mat_mem [MAT_ENTRIES];
  logic [31:0]        mem_rdata_r;
  logic               rd_en, mem_we;
  logic [1:0]         rd_row, rd_k;
  logic [MAT_AW-1:0]  rd_addr, wr_addr;
  logic               rd_v_r;
  logic [1:0]         rd_row_r, rd_k_r;

  logic               trig_vld;
  logic signed [16:0] st, ct, sa, ca;

  mac_op_t            mac_op;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  mac_op_t            ptag;
  mac_res_t           mres;
  logic signed [31:0] mres_val;

  logic               rowdone_r, pend_r;
  logic [1:0]         pend_row_r;
  logic signed [31:0] res_r [MAT_DIM];

  logic               out_vld_r, out_last_r;
  logic [1:0]         out_row_r;
  logic signed [31:0] out_col_r [MAT_DIM];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  // row finished and its word handed to the output register
  assign wait_go   = rowdone_r && !pend_r;

  dhfk_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .theta (in_tdata[40:31]),
    .alpha (in_tdata[8:0]),
    .vld   (trig_vld),
    .st    (st),
    .ct    (ct),
    .sa    (sa),
    .ca    (ca)
  );

  dhfk_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (mac_op),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .prod    (prod),
    .ptag    (ptag),
    .res     (mres),
    .res_val (mres_val)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_TRIG;
      S_TRIG: if (trig_vld) state_nxt = S_TERM;
      S_TERM: if (cnt_r == 4'(N_TERMS - 1)) state_nxt = S_MAC;
      S_MAC:  if (cnt_r == 4'hf) state_nxt = S_WAIT;
      S_WAIT: begin
        if (wait_go) begin
          if (row_r != ROW_LAST) state_nxt = S_MAC;
          else if (start_r)      state_nxt = S_IDLE;
          else                   state_nxt = S_ROW3;
        end
      end
      S_ROW3: if (out_free && !pend_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      row_r     <= '0;
      loaded_r  <= 1'b0;
      rd_v_r    <= 1'b0;
      rowdone_r <= 1'b0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt)
        cnt_r <= '0;
      else if (state_r == S_TERM || state_r == S_MAC)
        cnt_r <= cnt_r + 4'd1;

      if (in_acc)
        row_r <= '0;
      else if (state_r == S_WAIT && wait_go && row_r != ROW_LAST)
        row_r <= row_r + 2'd1;

      // every entry has been written once the first joint completes
      if (state_r == S_WAIT && wait_go && row_r == ROW_LAST)
        loaded_r <= 1'b1;

      rd_v_r <= rd_en;

      if (mres.vld && mres.col == COL_TR)
        rowdone_r <= 1'b1;
      else if (state_r == S_WAIT && wait_go)
        rowdone_r <= 1'b0;

      // pend: a complete row sits in res_r, not yet in the output register
      if (pend_r && out_free)
        pend_r <= 1'b0;
      else if (mres.vld && mres.col == COL_TR && !start_r)
        pend_r <= 1'b1;

      if (pend_r && out_free)
        out_vld_r <= 1'b1;
      else if (state_r == S_ROW3 && out_free)
        out_vld_r <= 1'b1;
      else if (out_tready)
        out_vld_r <= 1'b0;
    end
  end

  // ----------------------------------------------------------- joint capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r   <= in_tdata[19:9];
      off_r   <= in_tdata[30:20];
      start_r <= in_tuser;
    end
    if (ptag.vld && !ptag.acc) begin
      case (ptag.sel)
        TM_STCA: tm_r[TM_STCA] <= 32'(-prod);
        TM_STSA: tm_r[TM_STSA] <= prod[31:0];
        TM_CTCA: tm_r[TM_CTCA] <= prod[31:0];
        TM_CTSA: tm_r[TM_CTSA] <= 32'(-prod);
        TM_ACT:  tm_r[TM_ACT]  <= prod[31:0];
        TM_AST:  tm_r[TM_AST]  <= prod[31:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ running matrix RAM
  // Row 0 is fetched while the transform terms run; row i+1 is fetched during
  // the last four products of row i, each entry after its last use. Write-back
  // of row i never touches row i+1, so no forwarding is needed.
  always_comb begin
    rd_en  = 1'b0;
    rd_row = '0;
    rd_k   = cnt_r[1:0];
    if (state_r == S_TERM && cnt_r < 4'(MAT_DIM)) begin
      rd_en = 1'b1;
    end else if (state_r == S_MAC && cnt_r >= 4'd12 && row_r != ROW_LAST) begin
      rd_en  = 1'b1;
      rd_row = row_r + 2'd1;
    end
  end

  assign rd_addr = {rd_row, rd_k};
  assign mem_we  = mres.vld;
  assign wr_addr = {mres.row, mres.col};

  always_ff @(posedge clk) begin
    if (mem_we)
      mat_mem[wr_addr] <= mres_val;
    if (rd_en)
      mem_rdata_r <= mat_mem[rd_addr];
  end

  // a chain start multiplies the identity, as does every read before the
  // store holds a full matrix
  always_ff @(posedge clk) begin
    rd_row_r <= rd_row;
    rd_k_r   <= rd_k;
    if (rd_v_r) begin
      if (start_r || !loaded_r)
        mrow_r[rd_k_r] <= (rd_k_r == rd_row_r) ? ONE_FX : 32'sd0;
      else
        mrow_r[rd_k_r] <= mem_rdata_r;
    end
  end

  // ------------------------------------------------------- multiplier issue
  always_comb begin
    mac_op     = '0;
    mac_op.row = row_r;
    mul_a      = '0;
    mul_b      = '0;
    if (state_r == S_TERM) begin
      mac_op.vld = 1'b1;
      mac_op.sel = cnt_r[2:0];
      case (cnt_r[2:0])
        TM_STCA: begin mul_a = 32'(st);    mul_b = 32'(ca); end
        TM_STSA: begin mul_a = 32'(st);    mul_b = 32'(sa); end
        TM_CTCA: begin mul_a = 32'(ct);    mul_b = 32'(ca); end
        TM_CTSA: begin mul_a = 32'(ct);    mul_b = 32'(sa); end
        TM_ACT:  begin mul_a = 32'(len_r); mul_b = 32'(ct); end
        TM_AST:  begin mul_a = 32'(len_r); mul_b = 32'(st); end
        default: ;
      endcase
    end else if (state_r == S_MAC) begin
      // cnt = {column j, term k}: next[row][j] += m[row][k] * T[k][j]
      mac_op.vld   = 1'b1;
      mac_op.acc   = 1'b1;
      mac_op.first = (cnt_r[1:0] == 2'd0);
      mac_op.last  = (cnt_r[1:0] == 2'd3);
      mac_op.sel   = {1'b0, cnt_r[3:2]};
      mul_a        = mrow_r[cnt_r[1:0]];
      case ({cnt_r[1:0], cnt_r[3:2]})
        4'b00_00: mul_b = {ct, 15'd0};
        4'b00_01: mul_b = tm_r[TM_STCA];
        4'b00_10: mul_b = tm_r[TM_STSA];
        4'b00_11: mul_b = tm_r[TM_ACT];
        4'b01_00: mul_b = {st, 15'd0};
        4'b01_01: mul_b = tm_r[TM_CTCA];
        4'b01_10: mul_b = tm_r[TM_CTSA];
        4'b01_11: mul_b = tm_r[TM_AST];
        4'b10_01: mul_b = {sa, 15'd0};
        4'b10_10: mul_b = {ca, 15'd0};
        4'b10_11: mul_b = {{6{off_r[10]}}, off_r, 15'd0};
        4'b11_11: mul_b = 32'sd32768;  // own translation, 1.0 in Q.15
        default:  mul_b = '0;
      endcase
    end
  end

  // ----------------------------------------------------------- output words
  always_ff @(posedge clk) begin
    if (mres.vld)
      res_r[mres.col] <= mres_val;
    if (mres.vld && mres.col == COL_TR)
      pend_row_r <= mres.row;

    if (pend_r && out_free) begin
      out_row_r  <= pend_row_r;
      out_last_r <= 1'b0;
      for (int j = 0; j < MAT_DIM; j++)
        out_col_r[j] <= res_r[j];
    end else if (state_r == S_ROW3 && out_free) begin
      out_row_r  <= ROW_FIXED;
      out_last_r <= 1'b1;
      for (int j = 0; j < MAT_DIM; j++)
        out_col_r[j] <= (j == MAT_DIM - 1) ? ONE_FX : 32'sd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_col_r[3], out_col_r[2], out_col_r[1], out_col_r[0],
                       out_row_r};

  // ------------------------------------------------------------- assertions
  a_one_joint: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second joint accepted while one is in flight");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_r && !rowdone_r)
    else $error("idle with a row still pending");

  a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && rd_en |-> wr_addr != rd_addr)
    else $error("read and write-back hit the same matrix entry");

  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mres.vld |-> state_r != S_IDLE && state_r != S_ROW3)
    else $error("matrix entry finished outside a joint");

endmodule
